[hdl/ftc_pkg.sv]
package ftc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_PROBES    = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W       = $clog2(MAX_PROBES + 1);

  localparam logic [31:0] PKT_MAX  = '1;
  localparam logic [47:0] BYTE_MAX = '1;

  typedef enum logic [0:0] {
    CMD_COUNT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_COUNTED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_VALID = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_e;

  // One queued command, already classified by the front end
  typedef struct packed {
    cmd_e              cmd;
    logic [31:0]       sa;
    logic [15:0]       sp;
    logic [31:0]       da;
    logic [15:0]       dp;
    logic [15:0]       len;
    logic [IDX_W-1:0]  addr;
    logic              in_range;
  } item_t;

  // One table slot as stored in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [31:0] da;
    logic [15:0] dp;
    logic [31:0] pkts;
    logic [47:0] bytes;
  } entry_t;

  typedef struct packed {
    logic        done;
    status_e     status;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [31:0] da;
    logic [15:0] dp;
    logic [31:0] pkts;
    logic [47:0] bytes;
  } result_t;

  // Queue handshake between the front and back ends
  typedef struct packed {
    logic avail;
    logic clearing;
  } q_stat_t;

endpackage

[hdl/ftc_ram.sv]
module ftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/ftc_front.sv]
module ftc_front import ftc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        command_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] packet_length_i,
  input  logic [9:0]  entry_index_i,
  input  logic        clearing_i,
  input  logic        pop_i,
  output logic        busy_o,
  output q_stat_t     stat_o,
  output item_t       item_o
);

  item_t       fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic [33:0] hash;
  item_t       in_item;

  // Hash the key; the low bits pick the bucket for counts, reads use entry_index_i
  always_comb begin
    hash = ({2'b0, source_address_i ^ {17'b0, source_port_i[15:1]}} << 1)
         ^ ({2'b0, dest_address_i} << 1)
         ^ {18'b0, dest_port_i};
    in_item.cmd      = cmd_e'(command_i);
    in_item.sa       = source_address_i;
    in_item.sp       = source_port_i;
    in_item.da       = dest_address_i;
    in_item.dp       = dest_port_i;
    in_item.len      = packet_length_i;
    in_item.in_range = 1'b1;
    if (in_item.cmd == CMD_READ) begin
      in_item.addr     = IDX_W'(entry_index_i);
      in_item.in_range = {7'b0, entry_index_i} < 17'(TABLE_ENTRIES);
    end else begin
      in_item.addr = hash[IDX_W-1:0];
    end
  end

  assign busy_o = (cnt_q == 2'd2) | clearing_i;
  assign push   = start_i & ~busy_o;

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign item_o         = fifo_q[rptr_q];
  assign stat_o.avail   = cnt_q != 2'd0;
  assign stat_o.clearing = clearing_i;

endmodule

[hdl/ftc_back.sv]
module ftc_back import ftc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    clearing_o,
  output result_t res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ISSUE = 4'b0100,
    S_CHECK = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  item_t              cur_q;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [PROBE_W-1:0] probe_q, probe_d;
  result_t            res_q, res_d;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata, rdata;
  logic [48:0]        byte_sum;
  logic               key_hit;

  ftc_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign byte_sum = {1'b0, rdata.bytes} + {33'b0, cur_q.len};
  assign key_hit  = rdata.sa == cur_q.sa && rdata.sp == cur_q.sp &&
                    rdata.da == cur_q.da && rdata.dp == cur_q.dp;

  // Sweep the table after reset, then probe one slot at a time (issue the read, then check it)
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    probe_d = probe_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = '0;
    res_d   = res_q;
    res_d.done = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we     = 1'b1;
        addr_d = addr_q + 1'b1;
        if (&addr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.avail) begin
          pop_o   = 1'b1;
          addr_d  = item_i.addr;
          probe_d = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: state_d = S_CHECK;
      S_CHECK: begin
        res_d.done = 1'b1;
        res_d.sa   = cur_q.sa;
        res_d.sp   = cur_q.sp;
        res_d.da   = cur_q.da;
        res_d.dp   = cur_q.dp;
        state_d    = S_IDLE;
        if (cur_q.cmd == CMD_READ) begin
          if (rdata.valid && cur_q.in_range) begin
            res_d.status = ST_READ_VALID;
            res_d.sa     = rdata.sa;
            res_d.sp     = rdata.sp;
            res_d.da     = rdata.da;
            res_d.dp     = rdata.dp;
            res_d.pkts   = rdata.pkts;
            res_d.bytes  = rdata.bytes;
          end else begin
            res_d = '0;
            res_d.done   = 1'b1;
            res_d.status = ST_READ_EMPTY;
          end
        end else if (!rdata.valid) begin
          we           = 1'b1;
          wdata.valid  = 1'b1;
          wdata.sa     = cur_q.sa;
          wdata.sp     = cur_q.sp;
          wdata.da     = cur_q.da;
          wdata.dp     = cur_q.dp;
          wdata.pkts   = 32'd1;
          wdata.bytes  = {32'b0, cur_q.len};
          res_d.status = ST_INSERTED;
          res_d.pkts   = wdata.pkts;
          res_d.bytes  = wdata.bytes;
        end else if (key_hit) begin
          we          = 1'b1;
          wdata       = rdata;
          wdata.pkts  = (rdata.pkts == PKT_MAX) ? PKT_MAX : rdata.pkts + 32'd1;
          wdata.bytes = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
          res_d.status = ST_COUNTED;
          res_d.pkts   = wdata.pkts;
          res_d.bytes  = wdata.bytes;
        end else if (probe_q == PROBE_W'(MAX_PROBES - 1)) begin
          res_d.status = ST_FULL;
          res_d.pkts   = '0;
          res_d.bytes  = '0;
        end else begin
          // Step to the next slot, wrapping
          res_d.done = 1'b0;
          addr_d     = addr_q + 1'b1;
          probe_d    = probe_q + 1'b1;
          state_d    = S_ISSUE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Hold the current command
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      probe_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      probe_q <= probe_d;
      res_q   <= res_d;
    end
  end

  assign clearing_o = state_q == S_CLEAR;
  assign res_o      = res_q;

endmodule

[hdl/flow_tuple_traffic_counter.sv]
// Flow: a command waits in the front-end queue and is popped when the back end is idle.
// Each probe is a registered table read, then a compare; done_o comes from a register.
// The back end takes one command at a time; up to two more wait in the queue.
// Reset: after rst_ni the table is swept clear for TABLE_ENTRIES cycles with busy_o high.
// Results appear for one cycle on done_o; the receiver cannot stall.
module flow_tuple_traffic_counter import ftc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] packet_length_i,
  input  logic [9:0]  entry_index_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] flow_source_address_o,
  output logic [15:0] flow_source_port_o,
  output logic [31:0] flow_dest_address_o,
  output logic [15:0] flow_dest_port_o,
  output logic [31:0] flow_packets_o,
  output logic [47:0] flow_bytes_o
);

  q_stat_t stat;
  item_t   item;
  logic    pop, clearing;
  result_t res;

  ftc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .command_i        (command_i),
    .source_address_i (source_address_i),
    .source_port_i    (source_port_i),
    .dest_address_i   (dest_address_i),
    .dest_port_i      (dest_port_i),
    .packet_length_i  (packet_length_i),
    .entry_index_i    (entry_index_i),
    .clearing_i       (clearing),
    .pop_i            (pop),
    .busy_o           (busy_o),
    .stat_o           (stat),
    .item_o           (item)
  );

  ftc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .item_i     (item),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res)
  );

  assign done_o                = res.done;
  assign status_o              = res.status;
  assign flow_source_address_o = res.sa;
  assign flow_source_port_o    = res.sp;
  assign flow_dest_address_o   = res.da;
  assign flow_dest_port_o      = res.dp;
  assign flow_packets_o        = res.pkts;
  assign flow_bytes_o          = res.bytes;

endmodule
